// ===== rtl/bvq_pkg.sv =====
// Shared constants and types for the block variance core.
`timescale 1ns / 1ps

package bvq_pkg;

	localparam int COUNT_BITS = 16;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam int SAMPLE_W = 16;
	localparam int SUM_W    = 32;
	localparam int SQSUM_W  = 46;
	localparam int OPND_W   = 32;
	localparam int PROD_W   = 2 * OPND_W;
	localparam int VAR_W    = 16;
	localparam int SHIFT    = 15;

	localparam int DIV_STEPS = PROD_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_SETUP_A,
		ST_DIV_A,
		ST_MUL_SQ,
		ST_MUL_DEN,
		ST_DIV_B,
		ST_DONE
	} bvq_state_t;

endpackage

// ===== rtl/block_variance_q15_core.sv =====
// Unbiased Q15 block variance: accumulator front end and iterative divide back end.
`timescale 1ns / 1ps

// Usage
// The sample channel (sample_valid / sample_ready) carries one signed Q15 sample per
// request, with last marking the final sample of a block. The result channel
// (result_valid / result_ready) carries one variance and one too_long flag per block.
// Samples that are not last are taken one per cycle: the sum and sum of squares are
// updated in the cycle of acceptance. On a last sample the back end runs a sequence on
// one shared 32x32 multiplier and one shared restoring divider that produces one
// quotient bit per cycle over 64 steps. A setup step, the first division, the two
// multiplies and the second division run before result_valid; sample_ready is low
// meanwhile. A block of one sample, or one longer than 2^COUNT_BITS-1 samples, skips
// the back end and goes straight to the done state, whence its result enters the output register.
// The result sits in an output register, so a stalled receiver only holds the block
// when a second result is ready before the first was taken.
// Reset clears the sequencer, the accumulators and the output valid; no result is
// pending after reset.

module block_variance_q15_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_ready,
	input  logic signed [bvq_pkg::SAMPLE_W-1:0]  sample,
	input  logic                                 last,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic signed [bvq_pkg::VAR_W-1:0]     variance,
	output logic                                 too_long
);
	import bvq_pkg::*;

	bvq_state_t state_q, state_d;

	// Accumulators for the block in progress.
	logic [COUNT_BITS-1:0] cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SQSUM_W-1:0]    sqsum_q;
	logic                  ovf_q;
	logic                  zero_q;

	// Back end registers.
	logic [PROD_W-1:0]   dvd_q;
	logic [OPND_W-1:0]   rem_q;
	logic [OPND_W-1:0]   divisor_q;
	logic [STEP_W-1:0]   step_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SUM_W-1:0]    a_q;

	// Output register.
	logic                    result_valid_q;
	logic signed [VAR_W-1:0] variance_q;
	logic                    too_long_q;

	// Sequencer outputs.
	logic accept;
	logic div_run;
	logic result_load;
	logic last_step;

	// Front end arithmetic.
	logic [SUM_W-1:0]        sum_next;
	logic signed [SUM_W-1:0] sq_s;
	logic [SQSUM_W-1:0]      sqsum_next;
	logic [COUNT_BITS-1:0]   cnt_next;
	logic                    ovf_next;
	logic                    direct;

	// Shared units.
	logic [SUM_W-1:0]    mag;
	logic [OPND_W-1:0]   mul_a;
	logic [OPND_W-1:0]   mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [OPND_W:0]     rem_shift;
	logic [OPND_W+1:0]   rem_diff;
	logic                rem_ge;
	logic [SUM_W-1:0]    diff;

	assign accept    = sample_valid && sample_ready;
	assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));

	// The sum wraps at 32 bits and the sum of squares at 46 bits.
	assign sum_next   = sum_q + SUM_W'(sample);
	assign sq_s       = SUM_W'(sample) * SUM_W'(sample);
	assign sqsum_next = sqsum_q + SQSUM_W'(unsigned'(sq_s));
	assign ovf_next   = ovf_q || (cnt_q == COUNT_MAX);
	assign cnt_next   = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_BITS'(1);
	// Over-long and single-sample blocks both report a zero variance.
	assign direct     = ovf_next || (cnt_next <= COUNT_BITS'(1));

	// Magnitude of the wrapped sum; the most negative value maps onto 2^31 unchanged.
	assign mag   = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
	assign mul_a = (state_q == ST_MUL_SQ) ? OPND_W'(mag) : OPND_W'(cnt_q);
	assign mul_b = (state_q == ST_MUL_SQ) ? OPND_W'(mag) : OPND_W'(cnt_q - COUNT_BITS'(1));
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// One restoring divide step: shift in the next dividend bit, subtract if it fits.
	assign rem_shift = {rem_q, dvd_q[PROD_W-1]};
	assign rem_diff  = {1'b0, rem_shift} - {2'b00, divisor_q};
	assign rem_ge    = !rem_diff[OPND_W+1];

	// Both quotients are cut to 32 bits and subtracted with wrap.
	assign diff = a_q - dvd_q[SUM_W-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (accept && last) begin
					state_d = direct ? ST_DONE : ST_SETUP_A;
				end
			end
			ST_SETUP_A: state_d = ST_DIV_A;
			ST_DIV_A: begin
				if (last_step) begin
					state_d = ST_MUL_SQ;
				end
			end
			ST_MUL_SQ:  state_d = ST_MUL_DEN;
			ST_MUL_DEN: state_d = ST_DIV_B;
			ST_DIV_B: begin
				if (last_step) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (result_load) begin
					state_d = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		sample_ready = 1'b0;
		div_run      = 1'b0;
		result_load  = 1'b0;
		unique case (state_q)
			ST_ACCUM:         sample_ready = 1'b1;
			ST_DIV_A, ST_DIV_B: div_run    = 1'b1;
			ST_DONE:          result_load  = !result_valid_q || result_ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_ACCUM;
			cnt_q          <= '0;
			sum_q          <= '0;
			sqsum_q        <= '0;
			ovf_q          <= 1'b0;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q   <= cnt_next;
				sum_q   <= sum_next;
				sqsum_q <= sqsum_next;
				ovf_q   <= ovf_next;
			end else if (result_load) begin
				// The block is finished once its result moves to the output register.
				cnt_q   <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (div_run) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Back end datapath.
	always_ff @(posedge clk) begin
		if (accept && last) begin
			zero_q <= direct;
		end
		unique case (state_q)
			ST_SETUP_A: begin
				// A: sum of squares over N-1.
				dvd_q     <= PROD_W'(sqsum_q);
				rem_q     <= '0;
				divisor_q <= OPND_W'(cnt_q - COUNT_BITS'(1));
			end
			ST_DIV_A, ST_DIV_B: begin
				dvd_q <= {dvd_q[PROD_W-2:0], rem_ge};
				rem_q <= rem_ge ? rem_diff[OPND_W-1:0] : rem_shift[OPND_W-1:0];
			end
			ST_MUL_SQ: begin
				a_q    <= dvd_q[SUM_W-1:0];
				prod_q <= mul_p;
			end
			ST_MUL_DEN: begin
				// B: squared sum over N(N-1); the product fits in 32 bits.
				dvd_q     <= prod_q;
				rem_q     <= '0;
				divisor_q <= mul_p[OPND_W-1:0];
			end
			default: begin
			end
		endcase
		if (result_load) begin
			variance_q <= zero_q ? '0 : diff[SHIFT+VAR_W-1:SHIFT];
			too_long_q <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign variance     = variance_q;
	assign too_long     = too_long_q;

	// A result only appears after the sequencer has reached its final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared without a finished block");

	// An over-long block always reports zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && too_long |-> variance == '0)
		else $error("over-long block gave a nonzero variance");

	// The partial remainder stays below the divisor throughout a division.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_A || state_q == ST_DIV_B) |-> rem_q < divisor_q)
		else $error("divider remainder out of range");

	// Leaving the final state clears the block accumulators.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && result_load) |=> (cnt_q == '0 && !ovf_q && sum_q == '0))
		else $error("accumulators not cleared after a block");

endmodule
